@@ rtl/core/sil_pkg.sv @@
`timescale 1ns / 1ps

package sil_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int TAG_WIDTH     = 32;

    localparam int ADDR_W   = 32;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;
    localparam int IN_DATA_W  = 4 * FIELD_W;
    localparam int OUT_DATA_W = FIELD_W;

    // entry index and fill count; the count must also hold TABLE_ENTRIES itself
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [TAG_WIDTH-1:0] t_tag;

    typedef enum logic [0:0] {
        OP_ADD    = 1'b0,
        OP_LOCATE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  start;
        logic [FIELD_W-1:0] length;
        t_tag               tag;
        logic [ADDR_W-1:0]  addr;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [FIELD_W-1:0] length;
        t_tag               tag;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic t_tag tag_from_field(input logic [FIELD_W-1:0] f);
        logic [63:0] w;
        w = 64'(f);
        return w[TAG_WIDTH-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] tag_to_field(input t_tag t);
        logic [63:0] w;
        w = 64'(t);
        return w[FIELD_W-1:0];
    endfunction

endpackage

@@ rtl/core/sil_front.sv @@
`timescale 1ns / 1ps

module sil_front
    import sil_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,  // range_start, range_length, position_tag, query_address
    input  logic                 s_axis_tuser,  // mode
    input  t_q_status            i_q_status,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    logic w_accept;

    assign o_push        = r_valid && !i_q_status.full;
    assign s_axis_tready = !r_valid || !i_q_status.full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cmd         = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // decode the item into a command; tag is cut to the stored width here
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.op     <= t_op'(s_axis_tuser);
            r_cmd.start  <= s_axis_tdata[FIELD_W-1:0];
            r_cmd.length <= s_axis_tdata[2*FIELD_W-1:FIELD_W];
            r_cmd.tag    <= tag_from_field(s_axis_tdata[3*FIELD_W-1:2*FIELD_W]);
            r_cmd.addr   <= s_axis_tdata[4*FIELD_W-1:3*FIELD_W];
        end
    end

endmodule

@@ rtl/core/sil_queue.sv @@
`timescale 1ns / 1ps

module sil_queue
    import sil_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    t_cmd               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_status.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_cmd  = r_slot[r_rd_ptr];

    function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
        if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/core/sil_back.sv @@
`timescale 1ns / 1ps

module sil_back
    import sil_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  t_q_status             i_q_status,
    output logic                  o_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // found_tag
    output logic [STATUS_W-1:0]   m_axis_tuser   // status
);

    t_entry             r_mem [TABLE_ENTRIES];
    t_entry             r_rd_data;
    logic               r_rd_vld;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_issue;
    logic [ADDR_W-1:0]  r_addr;
    logic               r_have;
    logic [FIELD_W-1:0] r_best_len;
    t_tag               r_best_tag;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [FIELD_W-1:0] r_out_tag;
    t_status            n_out_status;
    logic [FIELD_W-1:0] n_out_tag;

    logic               w_out_free;
    logic               w_full;
    logic               w_scan_end;
    logic               w_hit;
    logic               w_better;
    logic               w_mem_we;
    logic               w_out_load;
    logic               w_scan_start;
    logic               w_rd_issue;
    logic [ADDR_W:0]    w_end;
    t_entry             w_new;

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_full     = (r_count == CNT_W'(TABLE_ENTRIES));
    assign w_scan_end = (r_issue == r_count);

    // range end is one bit wider so it cannot wrap
    assign w_end    = {1'b0, r_rd_data.start} + {1'b0, r_rd_data.length};
    assign w_hit    = (r_addr >= r_rd_data.start) && ({1'b0, r_addr} < w_end);
    // strict less-than keeps the earliest entry on equal lengths
    assign w_better = w_hit && (!r_have || (r_rd_data.length < r_best_len));

    assign w_new.start  = i_cmd.start;
    assign w_new.length = i_cmd.length;
    assign w_new.tag    = i_cmd.tag;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty && (i_cmd.op == OP_LOCATE)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_end && !r_rd_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop        = 1'b0;
        w_mem_we     = 1'b0;
        w_out_load   = 1'b0;
        w_scan_start = 1'b0;
        w_rd_issue   = 1'b0;
        n_out_status = ST_ADDED;
        n_out_tag    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    if (i_cmd.op == OP_ADD) begin
                        o_pop        = w_out_free;
                        w_out_load   = w_out_free;
                        w_mem_we     = w_out_free && !w_full;
                        n_out_status = w_full ? ST_FULL : ST_ADDED;
                    end else begin
                        o_pop        = 1'b1;
                        w_scan_start = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                w_rd_issue = !w_scan_end;
            end
            S_DONE: begin
                w_out_load   = w_out_free;
                n_out_status = r_have ? ST_FOUND : ST_NOT_FOUND;
                n_out_tag    = r_have ? tag_to_field(r_best_tag) : '0;
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_issue     <= '0;
            r_rd_vld    <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_issue;
            if (w_mem_we) begin
                r_count <= r_count + 1'b1;
            end
            if (w_scan_start) begin
                r_issue <= '0;
                r_have  <= 1'b0;
            end else if (w_rd_issue) begin
                r_issue <= r_issue + 1'b1;
            end
            if (r_rd_vld && w_better) begin
                r_have <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan_start) begin
            r_addr <= i_cmd.addr;
        end
        if (r_rd_vld && w_better) begin
            r_best_len <= r_rd_data.length;
            r_best_tag <= r_rd_data.tag;
        end
        if (w_out_load) begin
            r_out_status <= n_out_status;
            r_out_tag    <= n_out_tag;
        end
    end

    // range table: one write port at the fill count, one registered read port for the scan
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_count[IDX_W-1:0]] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_issue[IDX_W-1:0]];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tag;
    assign m_axis_tuser  = r_out_status;

endmodule

@@ rtl/core/smallest_interval_lookup.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake                      tdata                         tuser
// s_axis    in   s_axis_tvalid / s_axis_tready  start, length, tag, address   mode
// m_axis    out  m_axis_tvalid / m_axis_tready  found_tag                     status
//
// The single read port of the range table is scanned one entry per cycle.
// Reset is synchronous, active low; it empties the table and the queue, no clearing pass.
// An input register and a two-entry command queue let the input side run ahead
// while the scan or a stalled result holds the back end.

module smallest_interval_lookup
    import sil_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // range_start, range_length, position_tag, query_address
    input  logic                  s_axis_tuser,  // mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // found_tag
    output logic [STATUS_W-1:0]   m_axis_tuser   // status
);

    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;
    t_cmd      w_front_cmd;
    t_cmd      w_back_cmd;

    sil_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_status    (w_q_status),
        .o_push        (w_push),
        .o_cmd         (w_front_cmd)
    );

    sil_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_front_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_back_cmd),
        .o_status (w_q_status)
    );

    sil_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_back_cmd),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTH
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("push into full command queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty command queue");

    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_FOUND)) |-> (m_axis_tdata == '0))
        else $error("nonzero tag on a result that is not found");

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("command queue both full and empty");
`endif

endmodule
